@@ design/tmsf_pkg.sv @@
// Package for the temporal median scan filter: shared constants, register
// indexes and the controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps

package tmsf_pkg;

	// Default sizes, handed to the top-level parameters.
	localparam int DEF_MAX_BEAMS   = 1024;
	localparam int DEF_MAX_DEPTH   = 16;
	localparam int DEF_SAMPLE_BITS = 16;

	// Configuration port layout.
	localparam int WINDOW_DEPTH_BITS = 5;
	localparam int BEAMS_IN_USE_BITS = 11;
	localparam int CFG_DATA_BITS     = 11;
	localparam int CFG_INDEX_BITS    = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_DEPTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEAMS_IN_USE = 2'd1;

	localparam int RESET_WINDOW_DEPTH = 5;
	localparam int RESET_BEAMS_IN_USE = 360;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_sample; // capture the accepted sample and seed the sorter
		logic rd_en;       // read one history entry
		logic insert;      // insert the history word read last cycle
		logic wr_en;       // store the current sample into history
		logic pick_lo;     // capture the lower middle value
		logic out_load;    // form the result into the output register
	} tmsf_cmd_t;

endpackage

@@ design/tmsf_ifs.sv @@
// Handshake channel interfaces of the temporal median scan filter:
// sample input, result output and configuration write. Uses tmsf_pkg.
`timescale 1ns / 1ps

interface tmsf_in_if
	import tmsf_pkg::*;
	#(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] range_sample;

	modport source (output valid, output range_sample, input ready);
	modport sink (input valid, input range_sample, output ready);
endinterface

interface tmsf_out_if
	import tmsf_pkg::*;
	#(
		parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
		parameter int BEAM_BITS   = $clog2(DEF_MAX_BEAMS)
	);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS:0]   median_doubled;
	logic [BEAM_BITS-1:0]   beam_index;
	logic                   end_of_scan;

	modport source (output valid, output median_doubled, output beam_index,
		output end_of_scan, input ready);
	modport sink (input valid, input median_doubled, input beam_index,
		input end_of_scan, output ready);
endinterface

interface tmsf_cfg_if
	import tmsf_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/temporal_median_scan_filter.sv @@
// Top level of the temporal median scan filter: joins the controller and
// the datapath to the channel interfaces. Uses tmsf_pkg, tmsf_ifs,
// tmsf_ctrl and tmsf_datapath.
//
//   Channel   Direction  Contents
//   samples   in         range_sample, one range per beam in scan order
//   results   out        median_doubled, beam_index, end_of_scan
//   cfg       in         index and data of a register write
//
// A sample is accepted only while the sequencer is idle. For each item the
// sequencer reads the scans stored for its beam (at most the window depth)
// through the single read port of the history RAM, which feeds the
// insertion sorter one word per cycle, then picks the middle values.
// The result sits in an output register, so the next sample is accepted
// while it waits; a stalled output only holds the sequencer once the next
// result is ready. Reset is asynchronous and clears the counters and
// loads the default window depth and beam count. The history RAM is not
// cleared, since every entry is written before it is read.
`timescale 1ns / 1ps

module temporal_median_scan_filter
	import tmsf_pkg::*;
	#(
		parameter int MAX_BEAMS   = DEF_MAX_BEAMS,
		parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
		parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
	) (
	input  logic      clk,
	input  logic      arst_n,
	tmsf_cfg_if.sink  cfg,
	tmsf_in_if.sink   samples,
	tmsf_out_if.source results
);

	localparam int BEAM_BITS = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int SLOT_BITS = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// Command bundle and addressing from the controller to the datapath.
	tmsf_cmd_t            cmd;
	logic [SLOT_BITS-1:0] rd_slot;
	logic [SLOT_BITS-1:0] wr_slot;
	logic [BEAM_BITS-1:0] beam;
	logic                 last;

	// The controller owns every handshake and the scan bookkeeping.
	tmsf_ctrl #(
		.MAX_BEAMS (MAX_BEAMS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.rd_slot   (rd_slot),
		.wr_slot   (wr_slot),
		.beam      (beam),
		.last      (last)
	);

	// The datapath holds the history, sorts the window and forms the result.
	tmsf_datapath #(
		.MAX_BEAMS   (MAX_BEAMS),
		.MAX_DEPTH   (MAX_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.range_sample   (samples.range_sample),
		.rd_slot        (rd_slot),
		.wr_slot        (wr_slot),
		.beam           (beam),
		.last           (last),
		.median_doubled (results.median_doubled),
		.beam_index     (results.beam_index),
		.end_of_scan    (results.end_of_scan)
	);

endmodule

@@ design/tmsf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tmsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/tmsf_datapath.sv @@
// Datapath of the temporal median scan filter: history RAM, insertion
// sorter, median selection and output register. Uses tmsf_pkg, tmsf_ram.
`timescale 1ns / 1ps

module tmsf_datapath
	import tmsf_pkg::*;
	#(
		parameter int MAX_BEAMS   = DEF_MAX_BEAMS,
		parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
		parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
		localparam int BEAM_BITS  = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1,
		localparam int SLOT_BITS  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
	) (
	input  logic                   clk,
	input  tmsf_cmd_t              cmd,
	input  logic [SAMPLE_BITS-1:0] range_sample,
	input  logic [SLOT_BITS-1:0]   rd_slot,
	input  logic [SLOT_BITS-1:0]   wr_slot,
	input  logic [BEAM_BITS-1:0]   beam,
	input  logic                   last,
	output logic [SAMPLE_BITS:0]   median_doubled,
	output logic [BEAM_BITS-1:0]   beam_index,
	output logic                   end_of_scan
);

	localparam int DEPTH_CNT_BITS = $clog2(MAX_DEPTH + 1);
	localparam int RAM_DEPTH      = MAX_DEPTH * (2 ** BEAM_BITS);
	localparam int RAM_ADDR_BITS  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	logic [SAMPLE_BITS-1:0]    sample_q;
	logic [SAMPLE_BITS-1:0]    sorted_q [MAX_DEPTH];
	logic [SAMPLE_BITS-1:0]    sorted_nxt [MAX_DEPTH];
	logic [DEPTH_CNT_BITS-1:0] sort_cnt_q;
	logic [MAX_DEPTH-1:0]      below;
	logic [SAMPLE_BITS-1:0]    rd_data;
	logic [SAMPLE_BITS-1:0]    median_lo_q;
	logic [SAMPLE_BITS:0]      median_q;
	logic [BEAM_BITS-1:0]      beam_q;
	logic                      eos_q;
	logic [SLOT_BITS-1:0]      lo_idx;
	logic [SLOT_BITS-1:0]      hi_idx;
	logic [SAMPLE_BITS-1:0]    pick_val;
	logic [RAM_ADDR_BITS-1:0]  rd_addr;
	logic [RAM_ADDR_BITS-1:0]  wr_addr;

	// History is laid out as one row of beams per slot.
	assign rd_addr = RAM_ADDR_BITS'({rd_slot, beam});
	assign wr_addr = RAM_ADDR_BITS'({wr_slot, beam});

	tmsf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (RAM_DEPTH)
	) u_history (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (sample_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Each sorter cell compares the incoming word with its own entry; the
	// cells above the insertion point shift up by one.
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			below[i] = (DEPTH_CNT_BITS'(i) >= sort_cnt_q) || (rd_data < sorted_q[i]);
		end
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (!below[i]) begin
				sorted_nxt[i] = sorted_q[i];
			end else if (i == 0) begin
				sorted_nxt[i] = rd_data;
			end else if (!below[i-1]) begin
				sorted_nxt[i] = rd_data;
			end else begin
				sorted_nxt[i] = sorted_q[i-1];
			end
		end
	end

	assign lo_idx   = SLOT_BITS'((sort_cnt_q - DEPTH_CNT_BITS'(1)) >> 1);
	assign hi_idx   = SLOT_BITS'(sort_cnt_q >> 1);
	assign pick_val = sorted_q[cmd.pick_lo ? lo_idx : hi_idx];

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q    <= range_sample;
			sorted_q[0] <= range_sample;
			sort_cnt_q  <= DEPTH_CNT_BITS'(1);
		end else if (cmd.insert) begin
			sorted_q   <= sorted_nxt;
			sort_cnt_q <= sort_cnt_q + DEPTH_CNT_BITS'(1);
		end
		if (cmd.pick_lo) begin
			median_lo_q <= pick_val;
		end
		if (cmd.out_load) begin
			median_q <= {1'b0, median_lo_q} + {1'b0, pick_val};
			beam_q   <= beam;
			eos_q    <= last;
		end
	end

	assign median_doubled = median_q;
	assign beam_index     = beam_q;
	assign end_of_scan    = eos_q;

endmodule

@@ design/tmsf_ctrl.sv @@
// Controller of the temporal median scan filter: configuration registers,
// scan counters and the per-sample sequencer. Uses tmsf_pkg.
`timescale 1ns / 1ps

module tmsf_ctrl
	import tmsf_pkg::*;
	#(
		parameter int MAX_BEAMS  = DEF_MAX_BEAMS,
		parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
		localparam int BEAM_BITS = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1,
		localparam int SLOT_BITS = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
	) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output tmsf_cmd_t                 cmd,
	output logic [SLOT_BITS-1:0]      rd_slot,
	output logic [SLOT_BITS-1:0]      wr_slot,
	output logic [BEAM_BITS-1:0]      beam,
	output logic                      last
);

	localparam int DEPTH_CNT_BITS = $clog2(MAX_DEPTH + 1);
	localparam int BEAM_CNT_BITS  = $clog2(MAX_BEAMS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_LO    = 5'b01000,
		S_HI    = 5'b10000
	} state_t;

	function automatic logic [DEPTH_CNT_BITS-1:0] clamp_depth(
		input logic [WINDOW_DEPTH_BITS-1:0] raw);
		int v;
		v = int'(raw);
		if (v == 0) begin
			v = 1;
		end else if (v > MAX_DEPTH) begin
			v = MAX_DEPTH;
		end
		return DEPTH_CNT_BITS'(v);
	endfunction

	function automatic logic [BEAM_CNT_BITS-1:0] clamp_beams(
		input logic [BEAMS_IN_USE_BITS-1:0] raw);
		int v;
		v = int'(raw);
		if (v == 0) begin
			v = 1;
		end else if (v > MAX_BEAMS) begin
			v = MAX_BEAMS;
		end
		return BEAM_CNT_BITS'(v);
	endfunction

	state_t                    state_q;
	logic [DEPTH_CNT_BITS-1:0] window_q;
	logic [BEAM_CNT_BITS-1:0]  beams_q;
	logic [SLOT_BITS-1:0]      oldest_q;
	logic [DEPTH_CNT_BITS-1:0] scans_q;
	logic [BEAM_BITS-1:0]      beam_q;
	logic [SLOT_BITS-1:0]      rd_slot_q;
	logic                      rd_use_s1;
	logic                      out_valid_q;
	logic                      full;
	logic                      rd_last;
	logic                      rd_skip;
	logic                      out_free;
	logic                      accept;

	assign full     = (scans_q == window_q);
	assign rd_last  = ((DEPTH_CNT_BITS'(rd_slot_q) + DEPTH_CNT_BITS'(1)) == scans_q);
	assign rd_skip  = full && (rd_slot_q == oldest_q);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign rd_slot   = rd_slot_q;
	assign wr_slot   = full ? oldest_q : SLOT_BITS'(scans_q);
	assign beam      = beam_q;
	assign last      = ((BEAM_CNT_BITS'(beam_q) + BEAM_CNT_BITS'(1)) == beams_q);

	always_comb begin
		cmd.load_sample = accept;
		cmd.rd_en       = (state_q == S_READ);
		cmd.insert      = rd_use_s1;
		cmd.wr_en       = (state_q == S_LO);
		cmd.pick_lo     = (state_q == S_LO);
		cmd.out_load    = (state_q == S_HI) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= clamp_depth(WINDOW_DEPTH_BITS'(RESET_WINDOW_DEPTH));
			beams_q     <= clamp_beams(BEAMS_IN_USE_BITS'(RESET_BEAMS_IN_USE));
			oldest_q    <= '0;
			scans_q     <= '0;
			beam_q      <= '0;
			rd_slot_q   <= '0;
			rd_use_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_use_s1 <= (state_q == S_READ) && !rd_skip;

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					rd_slot_q <= '0;
					if (accept) begin
						state_q <= (scans_q == '0) ? S_LO : S_READ;
					end
				end
				S_READ: begin
					rd_slot_q <= rd_slot_q + SLOT_BITS'(1);
					if (rd_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_LO;
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (last) begin
							beam_q <= '0;
							if (!full) begin
								scans_q <= scans_q + DEPTH_CNT_BITS'(1);
							end else if ((DEPTH_CNT_BITS'(oldest_q) + DEPTH_CNT_BITS'(1))
									== window_q) begin
								oldest_q <= '0;
							end else begin
								oldest_q <= oldest_q + SLOT_BITS'(1);
							end
						end else begin
							beam_q <= beam_q + BEAM_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// A write to either configuration register restarts the scan bookkeeping.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WINDOW_DEPTH: begin
						window_q <= clamp_depth(cfg_data[WINDOW_DEPTH_BITS-1:0]);
						oldest_q <= '0;
						scans_q  <= '0;
						beam_q   <= '0;
					end
					REG_BEAMS_IN_USE: begin
						beams_q  <= clamp_beams(cfg_data[BEAMS_IN_USE_BITS-1:0]);
						oldest_q <= '0;
						scans_q  <= '0;
						beam_q   <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_scans_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scans_q <= window_q)
		else $error("stored scan count exceeds the window depth");

	a_oldest_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("oldest slot moved before the window filled");

	a_beam_bound: assert property (@(posedge clk) disable iff (!arst_n)
		BEAM_CNT_BITS'(beam_q) < beams_q)
		else $error("beam counter beyond the beams in use");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HI && !out_free) |=> (state_q == S_HI))
		else $error("result dropped while the output register was full");

	a_insert_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (state_q == S_READ || state_q == S_DRAIN))
		else $error("sorter insert outside the history read phase");

endmodule

@@ bench/temporal_median_scan_filter_test.sv @@
// Self-checking testbench for the temporal median scan filter. It drives
// samples and register writes, predicts every result and checks it.
// Depends on tmsf_pkg, the tmsf channel interfaces and the filter's top level.
`timescale 1ns / 1ps

module temporal_median_scan_filter_test;
	import tmsf_pkg::*;

	localparam int CLK_HALF_NS      = 6;
	localparam int RUN_LIMIT_CYCLES = 400000;
	// This tail leaves room for any stray result that would still come out.
	localparam int TAIL_CYCLES      = 40;
	localparam int MAX_BEAMS        = DEF_MAX_BEAMS;
	localparam int MAX_DEPTH        = DEF_MAX_DEPTH;
	localparam int SAMPLE_BITS      = DEF_SAMPLE_BITS;
	localparam int BEAM_BITS        = $clog2(MAX_BEAMS);
	localparam int MAX_REPORTS      = 10;

	// Indexes past the register list; a write there must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

	typedef logic [SAMPLE_BITS-1:0]   range_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

	typedef struct packed {
		logic [SAMPLE_BITS:0]   median_doubled;
		logic [BEAM_BITS-1:0]   beam_index;
		logic                   end_of_scan;
	} median_result_t;

	logic clk;
	logic arst_n;

	tmsf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if ();
	tmsf_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .BEAM_BITS(BEAM_BITS)) results_if ();
	tmsf_cfg_if cfg_if ();

	temporal_median_scan_filter #(
		.MAX_BEAMS  (MAX_BEAMS),
		.MAX_DEPTH  (MAX_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.samples(samples_if),
		.results(results_if)
	);

	always begin
		clk = 1'b0;
		#(CLK_HALF_NS);
		clk = 1'b1;
		#(CLK_HALF_NS);
	end

	// Shadow copy of the filter state. The history holds one slot per scan
	// in the window, each with one entry per beam.
	range_t                       scan_history [0:MAX_DEPTH-1][0:MAX_BEAMS-1];
	int unsigned                  oldest_scan;
	int unsigned                  scans_held;
	int unsigned                  next_beam;
	logic [WINDOW_DEPTH_BITS-1:0] depth_reg;
	logic [BEAMS_IN_USE_BITS-1:0] beams_reg;

	// Results predicted for accepted samples, oldest first.
	median_result_t pending_medians [$];

	int fail_count;
	bit sender_steady;
	bit sink_steady;
	int hold_off_cycles;

	function automatic void clear_scan_counters();
		oldest_scan = 0;
		scans_held  = 0;
		next_beam   = 0;
	endfunction

	function automatic void apply_register(logic [CFG_INDEX_BITS-1:0] idx, cfg_word_t data);
		case (idx)
			REG_WINDOW_DEPTH: begin
				depth_reg = data[WINDOW_DEPTH_BITS-1:0];
				clear_scan_counters();
			end
			REG_BEAMS_IN_USE: begin
				beams_reg = data[BEAMS_IN_USE_BITS-1:0];
				clear_scan_counters();
			end
			default: begin
			end
		endcase
	endfunction

	// Works out the result for one accepted sample and advances the shadow
	// state exactly as the filter does.
	function automatic median_result_t predict_median(range_t sample);
		int unsigned          eff_depth;
		int unsigned          eff_beams;
		int unsigned          beam;
		int unsigned          count;
		int unsigned          wslot;
		int unsigned          s;
		int unsigned          i;
		int unsigned          j;
		range_t               v;
		range_t               window [0:MAX_DEPTH];
		logic [SAMPLE_BITS:0] twice;
		median_result_t       res;

		// Out-of-range settings saturate into the supported range.
		eff_depth = (depth_reg == 0) ? 1 : ((depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg);
		eff_beams = (beams_reg == 0) ? 1 : ((beams_reg > MAX_BEAMS) ? MAX_BEAMS : beams_reg);

		beam = next_beam % eff_beams;
		if (oldest_scan >= eff_depth)
			oldest_scan = 0;
		if (scans_held > eff_depth)
			scans_held = eff_depth;

		// Once the window is full the oldest slot drops out, since the
		// current sample is about to take its place.
		window[0] = sample;
		count = 1;
		for (s = 0; s < scans_held; s++) begin
			if (!(scans_held >= eff_depth && s == oldest_scan)) begin
				window[count] = scan_history[s % MAX_DEPTH][beam];
				count++;
			end
		end

		for (i = 1; i < count; i++) begin
			v = window[i];
			j = i;
			while (j > 0 && window[j-1] > v) begin
				window[j] = window[j-1];
				j--;
			end
			window[j] = v;
		end

		// Twice the median keeps the mean of the two middle values exact.
		if (count[0])
			twice = {window[count/2], 1'b0};
		else
			twice = {1'b0, window[count/2-1]} + {1'b0, window[count/2]};

		wslot = (scans_held < eff_depth) ? scans_held : oldest_scan;
		scan_history[wslot % MAX_DEPTH][beam] = sample;

		res.median_doubled = twice;
		res.beam_index     = beam[BEAM_BITS-1:0];
		res.end_of_scan    = (beam + 1 >= eff_beams);

		if (res.end_of_scan) begin
			next_beam = 0;
			if (scans_held < eff_depth)
				scans_held++;
			else
				oldest_scan = (oldest_scan + 1) % eff_depth;
		end else begin
			next_beam = beam + 1;
		end
		return res;
	endfunction

	function automatic void flag_error(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// Mixes full-scale values, the two extremes and a narrow cluster that
	// produces ties and near-equal neighbors in the sort.
	function automatic range_t random_range();
		case ($urandom_range(0, 9)) inside
			0:       return '0;
			1:       return '1;
			[2:3]:   return range_t'(1000 + $urandom_range(0, 7));
			default: return range_t'($urandom);
		endcase
	endfunction

	// Offers one sample and waits for its transaction. The valid line is
	// left high afterwards, so with a steady sender back-to-back items never drop it in between.
	task automatic send_range(range_t r);
		while (!sender_steady && $urandom_range(0, 99) < 10) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid        <= 1'b1;
		samples_if.range_sample <= r;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		pending_medians.insert(pending_medians.size(), predict_median(r));
	endtask

	task automatic send_randoms(int count);
		repeat (count)
			send_range(random_range());
	endtask

	// Stops offering samples and waits until every predicted result is in.
	task automatic wait_for_results();
		samples_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_medians.size() != 0);
	endtask

	task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, cfg_word_t data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		apply_register(idx, data);
	endtask

	// Registers change only with the filter drained and idle.
	task automatic set_window(cfg_word_t depth_data, cfg_word_t beams_data);
		wait_for_results();
		write_register(REG_WINDOW_DEPTH, depth_data);
		write_register(REG_BEAMS_IN_USE, beams_data);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic write_spare(logic [CFG_INDEX_BITS-1:0] idx, cfg_word_t data);
		wait_for_results();
		write_register(idx, data);
		cfg_if.valid <= 1'b0;
	endtask

	// The defaults after reset: a long scan, so only the first beams show.
	task automatic test_reset_defaults();
		send_range(16'd1200);
		send_range(16'd0);
		send_range(16'hFFFF);
	endtask

	// One beam per scan and a window of four: counts of one to four values,
	// alternating extremes, so the even-count mean falls halfway between them.
	task automatic test_extremes_and_averaging();
		set_window(cfg_word_t'(4), cfg_word_t'(1));
		send_range(16'hFFFF);
		send_range(16'h0000);
		send_range(16'hFFFF);
		send_range(16'h0000);
		send_range(16'hFFFF);
		send_range(16'h0000);
		send_range(16'h0000);
	endtask

	// Zero settings behave as one, and a depth above the maximum saturates.
	task automatic test_register_clamping();
		set_window(cfg_word_t'(0), cfg_word_t'(0));
		send_range(16'hAAAA);
		send_range(16'h5555);
		set_window(cfg_word_t'(31), cfg_word_t'(2));
		send_range(16'h8000);
		send_range(16'h7FFF);
		send_range(16'h0001);
		send_range(16'hFFFE);
	endtask

	// Writes past the register list must leave the scan position alone, so
	// the beam count carries on across them.
	task automatic test_spare_registers();
		send_range(16'h1234);
		write_spare(REG_SPARE_2, cfg_word_t'($urandom));
		send_range(16'h4321);
		send_range(16'h00FF);
		write_spare(REG_SPARE_3, '1);
		send_range(16'hFF00);
	endtask

	// Full sixteen-scan window on a short scan, so the oldest slot wraps.
	task automatic test_deep_window();
		set_window(cfg_word_t'(16), cfg_word_t'(3));
		send_randoms(120);
	endtask

	task automatic test_no_idling();
		set_window(cfg_word_t'(7), cfg_word_t'(4));
		sender_steady = 1'b1;
		sink_steady   = 1'b1;
		send_randoms(120);
		sender_steady = 1'b0;
		sink_steady   = 1'b0;
	endtask

	// The receiver holds off for a long stretch while samples keep coming,
	// so the output register fills and the input side stalls.
	task automatic test_output_backpressure();
		set_window(cfg_word_t'(9), cfg_word_t'(5));
		hold_off_cycles = 250;
		send_randoms(60);
	endtask

	// The sender goes quiet until the filter has emptied, then resumes
	// mid-scan with the same settings.
	task automatic test_sender_pause();
		set_window(cfg_word_t'(3), cfg_word_t'(6));
		send_randoms(40);
		wait_for_results();
		send_randoms(40);
	endtask

	// Random settings; the upper data bits of a depth write must be ignored.
	task automatic test_random_settings();
		logic [CFG_DATA_BITS-WINDOW_DEPTH_BITS-1:0] junk;
		logic [WINDOW_DEPTH_BITS-1:0]               depth;

		repeat (6) begin
			junk  = (CFG_DATA_BITS-WINDOW_DEPTH_BITS)'($urandom);
			depth = WINDOW_DEPTH_BITS'($urandom_range(0, 31));
			set_window({junk, depth}, cfg_word_t'($urandom_range(0, 12)));
			send_randoms(35);
			if ($urandom_range(0, 1)) begin
				write_spare(($urandom_range(0, 1)) ? REG_SPARE_2 : REG_SPARE_3,
					cfg_word_t'($urandom));
				send_randoms(10);
			end
		end
	endtask

	// The largest scan: one complete pass to fill the history, then a few
	// beams of the next scan that use it.
	task automatic test_full_scan();
		set_window(cfg_word_t'(2), cfg_word_t'(MAX_BEAMS));
		send_randoms(MAX_BEAMS + 6);
	endtask

	// A beam count beyond the maximum with the shallowest window.
	task automatic test_beam_clamp();
		set_window(cfg_word_t'(1), '1);
		send_randoms(12);
	endtask

	// Receiver side: random ready, a steady stretch, and the long hold-off
	// counted down here one cycle at a time.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			results_if.ready <= 1'b0;
			hold_off_cycles--;
		end else if (sink_steady) begin
			results_if.ready <= 1'b1;
		end else begin
			results_if.ready <= ($urandom_range(0, 99) >= 10);
		end
	end

	// Every result transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		median_result_t got;
		median_result_t want;

		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got.median_doubled = results_if.median_doubled;
			got.beam_index     = results_if.beam_index;
			got.end_of_scan    = results_if.end_of_scan;
			if (pending_medians.size() == 0) begin
				flag_error($sformatf("result with nothing pending: median %0d beam %0d end %0b",
					got.median_doubled, got.beam_index, got.end_of_scan));
			end else begin
				want = pending_medians.pop_front();
				if (got.median_doubled !== want.median_doubled)
					flag_error($sformatf("median_doubled: expected %0d, got %0d (beam %0d)",
						want.median_doubled, got.median_doubled, want.beam_index));
				if (got.beam_index !== want.beam_index)
					flag_error($sformatf("beam_index: expected %0d, got %0d",
						want.beam_index, got.beam_index));
				if (got.end_of_scan !== want.end_of_scan)
					flag_error($sformatf("end_of_scan: expected %0b, got %0b (beam %0d)",
						want.end_of_scan, got.end_of_scan, want.beam_index));
			end
		end
	end

	initial begin
		#(RUN_LIMIT_CYCLES * 2 * CLK_HALF_NS);
		$display("temporal_median_scan_filter_test: errors");
		$finish;
	end

	initial begin
		arst_n                  = 1'b0;
		samples_if.valid        = 1'b0;
		samples_if.range_sample = '0;
		results_if.ready        = 1'b0;
		cfg_if.valid            = 1'b0;
		cfg_if.index            = REG_WINDOW_DEPTH;
		cfg_if.data             = '0;
		fail_count              = 0;
		sender_steady           = 1'b0;
		sink_steady             = 1'b0;
		hold_off_cycles         = 0;
		depth_reg               = WINDOW_DEPTH_BITS'(RESET_WINDOW_DEPTH);
		beams_reg               = BEAMS_IN_USE_BITS'(RESET_BEAMS_IN_USE);
		clear_scan_counters();

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_extremes_and_averaging();
		test_register_clamping();
		test_spare_registers();
		test_deep_window();
		test_no_idling();
		test_output_backpressure();
		test_sender_pause();
		test_random_settings();
		test_full_scan();
		test_beam_clamp();

		wait_for_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (fail_count == 0)
			$display("temporal_median_scan_filter_test: clean");
		else
			$display("temporal_median_scan_filter_test: errors");
		$finish;
	end

endmodule

@@ temporal_median_scan_filter.f @@
design/tmsf_pkg.sv
design/tmsf_ifs.sv
design/tmsf_ram.sv
design/tmsf_datapath.sv
design/tmsf_ctrl.sv
design/temporal_median_scan_filter.sv
bench/temporal_median_scan_filter_test.sv
